// File: rtl/first_fit_heap_allocator_unit_assert.svh
// Assertion macros for the first-fit heap allocator.
// Included by the top level; no other dependencies.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
// Check a property on the rising clock, off during reset.
`define FFH_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("heap allocator assertion failed");
// Check an implication on the rising clock, off during reset.
`define FFH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("heap allocator implication failed");
`else
`define FFH_ASSERT(lbl, clk, rstn, prop)
`define FFH_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/ffh_pkg.sv
// Package for the first-fit heap allocator: sizes, header record, status codes.
// No dependencies.
`timescale 1ns / 1ps
package ffh_pkg;
  localparam int unsigned HeapBytes   = 4096;
  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned AddrW       = $clog2(HeapBytes);
  localparam int unsigned PosW        = AddrW + 2;
  localparam int unsigned MinSplit    = HeaderBytes + 8;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [PosW-1:0]  pos_t;

  // One boundary-tag header; valid marks a real header position.
  typedef struct packed {
    logic  valid;
    logic  used;
    logic  last;
    addr_t prev;
    addr_t size;
  } hdr_t;

  localparam int unsigned HdrW = $bits(hdr_t);

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StNull     = 3'd1,
    StNoFit    = 3'd2,
    StBadPtr   = 3'd3,
    StNotAlloc = 3'd4
  } status_e;
endpackage

// File: rtl/ffh_if.sv
// Request and response channel interfaces of the heap allocator.
// Depends on ffh_pkg.
`timescale 1ns / 1ps
interface ffh_req_if;
  logic              valid;
  logic              ready;
  logic              mode;
  ffh_pkg::addr_t    request_bytes;
  ffh_pkg::addr_t    payload_offset;
  modport source (output valid, mode, request_bytes, payload_offset, input ready);
  modport sink   (input valid, mode, request_bytes, payload_offset, output ready);
endinterface

interface ffh_rsp_if;
  logic              valid;
  logic              ready;
  ffh_pkg::addr_t    result_offset;
  logic [2:0]        status;
  modport source (output valid, result_offset, status, input ready);
  modport sink   (input valid, result_offset, status, output ready);
endinterface

// File: rtl/ffh_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ffh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write one entry when enabled and read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: rtl/first_fit_heap_allocator_unit.sv
// First-fit boundary-tag heap allocator, top level.
// Depends on ffh_pkg, ffh_if, ffh_ram and the assertion header.
//
// One request at a time. After reset a clearing pass writes every header
// slot before the first request is taken. An allocate walks the block headers,
// each with a RAM read and a check, then does the split, the neighbor
// update and the response; a free reads, merges with free neighbors and
// responds. All steps share the single-port header RAM.
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_unit_assert.svh"
module first_fit_heap_allocator_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  ffh_req_if.sink       req_i,
  ffh_rsp_if.source     rsp_o
);
  typedef enum logic [3:0] {
    SClear, SIdle, SARd, SAChk, SAWNew, SFRd, SFChk, SFNRd, SFNChk,
    SFWh, SFPRd, SFPChk, SFInv, SFixRd, SFixWr, SFin
  } state_e;

  localparam ffh_pkg::pos_t HeapPos = ffh_pkg::pos_t'(ffh_pkg::HeapBytes);
  localparam ffh_pkg::pos_t HdrPos  = ffh_pkg::pos_t'(ffh_pkg::HeaderBytes);
  localparam ffh_pkg::addr_t HdrA   = ffh_pkg::addr_t'(ffh_pkg::HeaderBytes);
  localparam ffh_pkg::addr_t SplitA = ffh_pkg::addr_t'(ffh_pkg::MinSplit);
  localparam ffh_pkg::addr_t LastA  = ffh_pkg::addr_t'(ffh_pkg::HeapBytes - 1);

  state_e          state_q, state_d, fix_ret_q, fix_ret_d;
  ffh_pkg::addr_t  pos_q, pos_d, req_q, req_d, aux_q, aux_d;
  ffh_pkg::addr_t  hsz_q, hsz_d, hprev_q, hprev_d;
  logic            hlast_q, hlast_d;
  ffh_pkg::addr_t  fix_addr_q, fix_addr_d, fix_val_q, fix_val_d;
  ffh_pkg::addr_t  res_q, res_d, clr_q, clr_d;
  ffh_pkg::status_e st_q, st_d;
  logic            out_valid_q, out_valid_d;

  logic            ram_we;
  ffh_pkg::addr_t  ram_addr;
  ffh_pkg::hdr_t   ram_wdata, ram_rdata;
  logic [ffh_pkg::HdrW-1:0] ram_rraw;

  ffh_pkg::pos_t   follow_h, np, follow_w;
  ffh_pkg::addr_t  diff, merged;

  ffh_ram #(.Width(ffh_pkg::HdrW), .Depth(ffh_pkg::HeapBytes)) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rraw)
  );
  assign ram_rdata = ffh_pkg::hdr_t'(ram_rraw);

  assign req_i.ready         = (state_q == SIdle) && !out_valid_q;
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.result_offset = res_q;
  assign rsp_o.status        = st_q;

  // Shared address arithmetic
  assign follow_h = ffh_pkg::pos_t'(pos_q) + HdrPos + ffh_pkg::pos_t'(ram_rdata.size);
  assign np       = ffh_pkg::pos_t'(pos_q) + HdrPos + ffh_pkg::pos_t'(req_q);
  assign diff     = ram_rdata.size - req_q;
  assign merged   = hsz_q + ram_rdata.size + HdrA;
  assign follow_w = ffh_pkg::pos_t'(aux_q) + HdrPos + ffh_pkg::pos_t'(hsz_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    fix_ret_d   = fix_ret_q;
    pos_d       = pos_q;
    req_d       = req_q;
    aux_d       = aux_q;
    hsz_d       = hsz_q;
    hprev_d     = hprev_q;
    hlast_d     = hlast_q;
    fix_addr_d  = fix_addr_q;
    fix_val_d   = fix_val_q;
    res_d       = res_q;
    clr_d       = clr_q;
    st_d        = st_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_addr    = pos_q;
    ram_wdata   = ram_rdata;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      SClear: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        if (clr_q == '0) begin
          ram_wdata = '{valid: 1'b1, used: 1'b0, last: 1'b1, prev: '0,
                        size: ffh_pkg::addr_t'(ffh_pkg::HeapBytes - ffh_pkg::HeaderBytes)};
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == LastA) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (req_i.valid && req_i.ready) begin
          res_d = '0;
          if (!req_i.mode) begin
            req_d = req_i.request_bytes;
            pos_d = '0;
            if (req_i.request_bytes == '0) begin
              st_d    = ffh_pkg::StNull;
              state_d = SFin;
            end else begin
              state_d = SARd;
            end
          end else begin
            pos_d = req_i.payload_offset - HdrA;
            if (req_i.payload_offset == '0) begin
              st_d    = ffh_pkg::StNull;
              state_d = SFin;
            end else if (req_i.payload_offset < HdrA) begin
              st_d    = ffh_pkg::StBadPtr;
              state_d = SFin;
            end else begin
              state_d = SFRd;
            end
          end
        end
      end
      SARd: state_d = SAChk;
      SAChk: begin
        // Take, split or step past the header just read, or report no fit
        if (!ram_rdata.valid) begin
          st_d    = ffh_pkg::StNoFit;
          state_d = SFin;
        end else if (!ram_rdata.used && ram_rdata.size >= req_q) begin
          ram_we         = 1'b1;
          ram_wdata.used = 1'b1;
          res_d          = pos_q + HdrA;
          st_d           = ffh_pkg::StOk;
          aux_d          = np[ffh_pkg::AddrW-1:0];
          hsz_d          = diff - HdrA;
          hlast_d        = ram_rdata.last;
          if (diff >= SplitA && np < HeapPos) begin
            ram_wdata.size = req_q;
            ram_wdata.last = 1'b0;
            state_d        = SAWNew;
          end else begin
            state_d = SFin;
          end
        end else if (ram_rdata.last || follow_h >= HeapPos) begin
          st_d    = ffh_pkg::StNoFit;
          state_d = SFin;
        end else begin
          pos_d   = follow_h[ffh_pkg::AddrW-1:0];
          state_d = SARd;
        end
      end
      SAWNew: begin
        ram_we    = 1'b1;
        ram_addr  = aux_q;
        ram_wdata = '{valid: 1'b1, used: 1'b0, last: hlast_q, prev: req_q, size: hsz_q};
        if (!hlast_q && follow_w < HeapPos) begin
          fix_addr_d = follow_w[ffh_pkg::AddrW-1:0];
          fix_val_d  = hsz_q;
          fix_ret_d  = SFin;
          state_d    = SFixRd;
        end else begin
          state_d = SFin;
        end
      end
      SFRd: state_d = SFChk;
      SFChk: begin
        hsz_d   = ram_rdata.size;
        hprev_d = ram_rdata.prev;
        hlast_d = ram_rdata.last;
        if (!ram_rdata.valid) begin
          st_d    = ffh_pkg::StBadPtr;
          state_d = SFin;
        end else if (!ram_rdata.used) begin
          st_d    = ffh_pkg::StNotAlloc;
          state_d = SFin;
        end else begin
          st_d = ffh_pkg::StOk;
          if (!ram_rdata.last && follow_h < HeapPos) begin
            aux_d   = follow_h[ffh_pkg::AddrW-1:0];
            state_d = SFNRd;
          end else begin
            state_d = SFWh;
          end
        end
      end
      SFNRd: begin
        ram_addr = aux_q;
        state_d  = SFNChk;
      end
      SFNChk: begin
        // Absorb a free next neighbor
        ram_addr = aux_q;
        state_d  = SFWh;
        if (!ram_rdata.used) begin
          ram_we          = 1'b1;
          ram_wdata.valid = 1'b0;
          hsz_d           = merged;
          hlast_d         = ram_rdata.last;
          if (!ram_rdata.last && (ffh_pkg::pos_t'(pos_q) + HdrPos +
                                  ffh_pkg::pos_t'(merged)) < HeapPos) begin
            fix_addr_d = pos_q + HdrA + merged;
            fix_val_d  = merged;
            fix_ret_d  = SFWh;
            state_d    = SFixRd;
          end
        end
      end
      SFWh: begin
        ram_we    = 1'b1;
        ram_wdata = '{valid: 1'b1, used: 1'b0, last: hlast_q, prev: hprev_q, size: hsz_q};
        if (pos_q != '0 && ffh_pkg::pos_t'(pos_q) >= ffh_pkg::pos_t'(hprev_q) + HdrPos) begin
          aux_d   = pos_q - hprev_q - HdrA;
          state_d = SFPRd;
        end else begin
          state_d = SFin;
        end
      end
      SFPRd: begin
        ram_addr = aux_q;
        state_d  = SFPChk;
      end
      SFPChk: begin
        // Absorb this block into a free previous neighbor
        ram_addr = aux_q;
        if (ram_rdata.valid && !ram_rdata.used) begin
          ram_we         = 1'b1;
          ram_wdata.size = merged;
          ram_wdata.last = hlast_q;
          hsz_d          = merged;
          state_d        = SFInv;
        end else begin
          state_d = SFin;
        end
      end
      SFInv: begin
        ram_we    = 1'b1;
        ram_wdata = '{valid: 1'b0, used: 1'b0, last: hlast_q, prev: hprev_q, size: hsz_q};
        if (!hlast_q && follow_w < HeapPos) begin
          fix_addr_d = follow_w[ffh_pkg::AddrW-1:0];
          fix_val_d  = hsz_q;
          fix_ret_d  = SFin;
          state_d    = SFixRd;
        end else begin
          state_d = SFin;
        end
      end
      SFixRd: begin
        ram_addr = fix_addr_q;
        state_d  = SFixWr;
      end
      SFixWr: begin
        ram_we         = 1'b1;
        ram_addr       = fix_addr_q;
        ram_wdata.prev = fix_val_q;
        state_d        = fix_ret_q;
      end
      SFin: begin
        out_valid_d = 1'b1;
        state_d     = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      fix_ret_q   <= SFin;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      st_q        <= ffh_pkg::StOk;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      fix_ret_q   <= fix_ret_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      st_q        <= st_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    req_q      <= req_d;
    aux_q      <= aux_d;
    hsz_q      <= hsz_d;
    hprev_q    <= hprev_d;
    hlast_q    <= hlast_d;
    fix_addr_q <= fix_addr_d;
    fix_val_q  <= fix_val_d;
  end

  // Checks
  `FFH_ASSERT_IMP(a_no_accept_clear, clk_i, rst_ni, state_q == SClear, !req_i.ready)
  `FFH_ASSERT_IMP(a_idle_no_write, clk_i, rst_ni, state_q == SIdle, !ram_we)
  `FFH_ASSERT_IMP(a_offset_ok, clk_i, rst_ni, out_valid_q && res_q != '0, st_q == ffh_pkg::StOk)
  `FFH_ASSERT(a_fin_sets_valid, clk_i, rst_ni, (state_q == SFin) |=> out_valid_q)
endmodule

// File: dv/testbench.sv
// Self-checking testbench for the first-fit heap allocator unit.
// Depends on ffh_pkg, ffh_if and the top level; a shadow heap predicts every response.
`timescale 1ns / 1ps
module testbench;
  localparam int unsigned CycleLimit = 6000000;
  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  typedef struct {
    ffh_pkg::addr_t   off;
    ffh_pkg::status_e st;
  } heap_result_t;

  logic clk_i;
  logic rst_ni;

  ffh_req_if req_if ();
  ffh_rsp_if rsp_if ();

  first_fit_heap_allocator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the header chain
  int unsigned blk_size [ffh_pkg::HeapBytes];
  int unsigned blk_prev [ffh_pkg::HeapBytes];
  bit          blk_used [ffh_pkg::HeapBytes];
  bit          blk_last [ffh_pkg::HeapBytes];
  bit          blk_hdr_ok [ffh_pkg::HeapBytes];

  heap_result_t pending_results[$];
  int           live_ptrs[$];
  int           error_count;
  int unsigned  cycle_count;
  int           rsp_hold;
  int           burst_left;
  bit           no_gaps;

  // Clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic int unsigned next_hdr(int unsigned pos);
    return pos + ffh_pkg::HeaderBytes + blk_size[pos];
  endfunction

  // Tell the block after pos its new previous size
  function automatic void relink_next(int unsigned pos);
    int unsigned n;
    if (blk_last[pos]) return;
    n = next_hdr(pos);
    if (n < ffh_pkg::HeapBytes) blk_prev[n] = blk_size[pos];
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < ffh_pkg::HeapBytes; i++) begin
      blk_size[i] = 0;
      blk_prev[i] = 0;
      blk_used[i] = 0;
      blk_last[i] = 0;
      blk_hdr_ok[i] = 0;
    end
    blk_size[0] = ffh_pkg::HeapBytes - ffh_pkg::HeaderBytes;
    blk_last[0] = 1;
    blk_hdr_ok[0] = 1;
  endfunction

  // Walk the chain from zero and take the first free block that fits
  function automatic heap_result_t predict_alloc(int unsigned req);
    heap_result_t r;
    int unsigned pos;
    int unsigned old;
    int unsigned np;
    r.off = '0;
    r.st = ffh_pkg::StNoFit;
    pos = 0;
    if (req == 0) begin
      r.st = ffh_pkg::StNull;
      return r;
    end
    for (int guard = 0; guard < ffh_pkg::HeapBytes; guard++) begin
      if (pos >= ffh_pkg::HeapBytes || !blk_hdr_ok[pos]) return r;
      if (!blk_used[pos] && blk_size[pos] >= req) begin
        old = blk_size[pos];
        blk_used[pos] = 1;
        if (old - req >= ffh_pkg::MinSplit) begin
          np = pos + ffh_pkg::HeaderBytes + req;
          if (np < ffh_pkg::HeapBytes) begin
            blk_used[np] = 0;
            blk_size[np] = old - ffh_pkg::HeaderBytes - req;
            blk_last[np] = blk_last[pos];
            blk_prev[np] = req;
            blk_hdr_ok[np] = 1;
            blk_size[pos] = req;
            blk_last[pos] = 0;
            relink_next(np);
          end
        end
        r.off = ffh_pkg::addr_t'(pos + ffh_pkg::HeaderBytes);
        r.st = ffh_pkg::StOk;
        return r;
      end
      if (blk_last[pos]) return r;
      pos = next_hdr(pos);
    end
    return r;
  endfunction

  // Clear the mark and merge with free neighbors
  function automatic heap_result_t predict_free(int unsigned off);
    heap_result_t r;
    int unsigned hp;
    int unsigned n;
    int unsigned pp;
    r.off = '0;
    r.st = ffh_pkg::StOk;
    if (off == 0) begin
      r.st = ffh_pkg::StNull;
      return r;
    end
    if (off < ffh_pkg::HeaderBytes || off >= ffh_pkg::HeapBytes) begin
      r.st = ffh_pkg::StBadPtr;
      return r;
    end
    hp = off - ffh_pkg::HeaderBytes;
    if (!blk_hdr_ok[hp]) begin
      r.st = ffh_pkg::StBadPtr;
      return r;
    end
    if (!blk_used[hp]) begin
      r.st = ffh_pkg::StNotAlloc;
      return r;
    end
    blk_used[hp] = 0;
    if (!blk_last[hp]) begin
      n = next_hdr(hp);
      if (n < ffh_pkg::HeapBytes && !blk_used[n]) begin
        blk_size[hp] = blk_size[hp] + blk_size[n] + ffh_pkg::HeaderBytes;
        blk_last[hp] = blk_last[n];
        blk_hdr_ok[n] = 0;
        relink_next(hp);
      end
    end
    if (hp != 0 && hp >= blk_prev[hp] + ffh_pkg::HeaderBytes) begin
      pp = hp - blk_prev[hp] - ffh_pkg::HeaderBytes;
      if (blk_hdr_ok[pp] && !blk_used[pp]) begin
        blk_size[pp] = blk_size[pp] + blk_size[hp] + ffh_pkg::HeaderBytes;
        blk_last[pp] = blk_last[hp];
        blk_hdr_ok[hp] = 0;
        relink_next(pp);
      end
    end
    return r;
  endfunction

  // Offer one request, wait for the transfer, predict its response
  task automatic send_request(input logic mode, input int unsigned req_bytes,
                              input int unsigned off, output heap_result_t r);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!no_gaps && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 10);
    end
    burst_left--;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.mode <= mode;
    req_if.request_bytes <= ffh_pkg::addr_t'(req_bytes);
    req_if.payload_offset <= ffh_pkg::addr_t'(off);
    do @(posedge clk_i); while (!req_if.ready);
    if (mode == ModeAlloc) r = predict_alloc(req_bytes);
    else r = predict_free(off);
    pending_results.push_back(r);
  endtask

  task automatic do_alloc(input int unsigned req_bytes);
    heap_result_t r;
    send_request(ModeAlloc, req_bytes, $urandom_range(0, 4095), r);
    if (r.st == ffh_pkg::StOk) live_ptrs.push_back(r.off);
  endtask

  task automatic do_free(input int unsigned off);
    heap_result_t r;
    send_request(ModeFree, $urandom_range(0, 4095), off, r);
    if (r.st == ffh_pkg::StOk) begin
      foreach (live_ptrs[i]) begin
        if (live_ptrs[i] == off) begin
          live_ptrs.delete(i);
          break;
        end
      end
    end
  endtask

  // Free a random live pointer
  task automatic free_live();
    int idx;
    idx = $urandom_range(0, live_ptrs.size() - 1);
    do_free(live_ptrs[idx]);
  endtask

  // Hold the sender until every response has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Every status code and the field extremes
  task automatic test_directed();
    do_alloc(0);
    do_free(0);
    do_free(4);
    do_free(4095);
    do_alloc(4095);
    do_alloc(4088);
    do_free(8);
    do_alloc(4072);
    do_free(8);
    do_free(8);
    do_alloc(2048);
    do_free(12);
    do_free(8);
    do_alloc(100);
    do_alloc(200);
    do_alloc(300);
    do_free(116);
    do_free(8);
    do_free(324);
    do_alloc(1365);
    do_alloc(2730);
    do_alloc(1);
    while (live_ptrs.size() != 0) free_live();
    drain();
  endtask

  // Fill the heap until nothing fits, then free in random order
  task automatic test_fill_and_empty();
    heap_result_t r;
    r.st = ffh_pkg::StOk;
    while (r.st == ffh_pkg::StOk) begin
      send_request(ModeAlloc, $urandom_range(16, 300), 0, r);
      if (r.st == ffh_pkg::StOk) live_ptrs.push_back(r.off);
    end
    while (live_ptrs.size() != 0) free_live();
    drain();
  endtask

  // Receiver holds off long while requests keep coming
  task automatic test_backpressure();
    rsp_hold = 3000;
    for (int i = 0; i < 20; i++) begin
      if (live_ptrs.size() > 0 && $urandom_range(0, 1)) free_live();
      else do_alloc($urandom_range(1, 128));
    end
    drain();
  endtask

  // Mostly well-formed alloc/free traffic with some noise
  task automatic test_random(input int n_items);
    int pick;
    for (int i = 0; i < n_items; i++) begin
      if (i % 300 == 0) no_gaps = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      if (pick < 50 && live_ptrs.size() < 40) begin
        if ($urandom_range(0, 19) == 0) do_alloc($urandom_range(1, 4095));
        else do_alloc($urandom_range(1, 96));
      end else if (pick < 88 && live_ptrs.size() > 0) begin
        free_live();
      end else if (pick < 92) begin
        do_free($urandom_range(0, 4095));
      end else if (pick < 95 && live_ptrs.size() > 0) begin
        do_free(live_ptrs[$urandom_range(0, live_ptrs.size() - 1)] + 4);
      end else if (pick < 97) begin
        do_alloc(0);
      end else begin
        do_alloc($urandom_range(1, 64));
      end
      if (i == n_items / 2) drain();
    end
    drain();
  endtask

  // Response check and receiver stall pattern
  initial begin
    int stall_pct;
    heap_result_t want;
    stall_pct = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected response off=%0d st=%0d", $time,
                   rsp_if.result_offset, rsp_if.status);
        end else begin
          want = pending_results.pop_front();
          if (rsp_if.result_offset !== want.off) begin
            error_count++;
            $display("%0t: result_offset expected %0d actual %0d", $time, want.off,
                     rsp_if.result_offset);
          end
          if (rsp_if.status !== want.st) begin
            error_count++;
            $display("%0t: status expected %0d actual %0d", $time, want.st,
                     rsp_if.status);
          end
        end
      end
      if (cycle_count % 256 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 25;
          default: stall_pct = 60;
        endcase
      end
      if (rsp_hold > 0) begin
        rsp_hold--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    rsp_hold = 0;
    burst_left = 0;
    no_gaps = 0;
    shadow_reset();
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.mode <= ModeAlloc;
    req_if.request_bytes <= '0;
    req_if.payload_offset <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_and_empty();
    test_backpressure();
    test_random(1450);
    test_fill_and_empty();

    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
